/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both forms take a label, a clock,
// an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/ucap_pkg.sv */
`timescale 1ns / 1ps

package ucap_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W    = 16;
    localparam int CAPS_W  = 32;

    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [ID_W-1:0]   ROOT_ID   = '0;
    localparam logic [CAPS_W-1:0] ROOT_CAPS = '1;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   user_id;
        logic [CAPS_W-1:0] caps;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   user_id;
        logic [CAPS_W-1:0] caps;
    } t_write;

    typedef struct packed {
        logic              hit;
        logic [CAPS_W-1:0] caps;
        logic              has_free;
        logic [IDX_W-1:0]  free_idx;
    } t_search;

endpackage

/* hw/rtl/user_capability_table_unit.sv */
`timescale 1ns / 1ps
// A request is taken into the request registers and looked up in the table; its
// result, marked by o_done, is then taken into the result registers.
// Throughput: one request per cycle; busy stays low, as the table search
// and update finish within the single stage between the request and result
// registers. The receiver cannot stall the result.
// Reset (synchronous, active low) leaves only the root entry valid at once.

`include "assert_macros.svh"

module user_capability_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [ucap_pkg::ID_W-1:0]     i_user_id,
    input  logic [ucap_pkg::CAPS_W-1:0]   i_grant_mask,
    input  logic [ucap_pkg::CAPS_W-1:0]   i_required_mask,
    output logic                          o_done,
    output logic                          o_success,
    output logic [ucap_pkg::CAPS_W-1:0]   o_granted_caps,
    output logic                          o_covers_required
);

    logic                          r_req_vld;
    logic                          r_req_kind;
    logic [ucap_pkg::ID_W-1:0]     r_req_id;
    logic [ucap_pkg::CAPS_W-1:0]   r_req_grant;
    logic [ucap_pkg::CAPS_W-1:0]   r_req_required;

    logic                          r_done;
    logic                          r_res_query;
    logic                          r_success;
    logic [ucap_pkg::CAPS_W-1:0]   r_caps;
    logic                          r_covers;

    logic                          n_success;
    logic [ucap_pkg::CAPS_W-1:0]   n_caps;
    logic                          n_covers;

    ucap_pkg::t_entry              tbl [ucap_pkg::ENTRIES];
    ucap_pkg::t_search             srch;
    ucap_pkg::t_write              wr;
    logic [ucap_pkg::ENTRIES-1:0]  valid_vec;
    logic                          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_kind     <= i_kind;
            r_req_id       <= i_user_id;
            r_req_grant    <= i_grant_mask;
            r_req_required <= i_required_mask;
        end
    end

    ucap_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_tbl   (tbl)
    );

    ucap_search u_search (
        .i_tbl     (tbl),
        .i_user_id (r_req_id),
        .o_srch    (srch)
    );

    always_comb begin
        wr.en      = r_req_vld && (r_req_kind == ucap_pkg::KIND_CREATE)
                     && !srch.hit && srch.has_free;
        wr.idx     = srch.free_idx;
        wr.user_id = r_req_id;
        wr.caps    = r_req_grant;
    end

    always_comb begin
        n_success = 1'b0;
        n_caps    = '0;
        n_covers  = 1'b0;
        unique case (r_req_kind)
            ucap_pkg::KIND_CREATE: begin
                n_success = !srch.hit && srch.has_free;
            end
            ucap_pkg::KIND_QUERY: begin
                n_success = srch.hit;
                n_caps    = srch.caps;
                n_covers  = ((srch.caps & r_req_required) == r_req_required);
            end
            default: begin
                n_success = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_res_query <= (r_req_kind == ucap_pkg::KIND_QUERY);
            r_success   <= n_success;
            r_caps      <= n_caps;
            r_covers    <= n_covers;
        end
    end

    assign o_done            = r_done;
    assign o_success         = r_success;
    assign o_granted_caps    = r_caps;
    assign o_covers_required = r_covers;

    for (genvar g = 0; g < ucap_pkg::ENTRIES; g++) begin : g_valid
        assign valid_vec[g] = tbl[g].valid;
    end

    // The root entry can never be freed or overwritten.
    `ASSERT_IMPLY(a_root_kept, i_clk, i_rst_n, 1'b1, valid_vec[0])

    // A stored create fills exactly one previously free slot.
    `ASSERT_NEXT(a_create_fills_one, i_clk, i_rst_n, wr.en, $countones(valid_vec) == $countones($past(valid_vec)) + 1)

    // Create results never report capabilities.
    `ASSERT_IMPLY(a_create_no_caps, i_clk, i_rst_n, o_done && !r_res_query, (o_granted_caps == '0) && !o_covers_required)

    // A query that finds no entry reports an empty mask.
    `ASSERT_IMPLY(a_miss_no_caps, i_clk, i_rst_n, o_done && r_res_query && !o_success, o_granted_caps == '0)

endmodule

/* hw/rtl/ucap_table.sv */
`timescale 1ns / 1ps

module ucap_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ucap_pkg::t_write i_wr,
    output ucap_pkg::t_entry o_tbl [ucap_pkg::ENTRIES]
);

    ucap_pkg::t_entry r_tbl [ucap_pkg::ENTRIES];

    // Entry zero holds the root user after reset; the other entries only
    // need their valid bit cleared.
    for (genvar g = 0; g < ucap_pkg::ENTRIES; g++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tbl[g].valid <= (g == 0);
                if (g == 0) begin
                    r_tbl[g].user_id <= ucap_pkg::ROOT_ID;
                    r_tbl[g].caps    <= ucap_pkg::ROOT_CAPS;
                end
            end else if (i_wr.en && (i_wr.idx == ucap_pkg::IDX_W'(g))) begin
                r_tbl[g].valid   <= 1'b1;
                r_tbl[g].user_id <= i_wr.user_id;
                r_tbl[g].caps    <= i_wr.caps;
            end
        end
        assign o_tbl[g] = r_tbl[g];
    end

endmodule

/* hw/rtl/ucap_search.sv */
`timescale 1ns / 1ps

module ucap_search (
    input  ucap_pkg::t_entry            i_tbl [ucap_pkg::ENTRIES],
    input  logic [ucap_pkg::ID_W-1:0]   i_user_id,
    output ucap_pkg::t_search           o_srch
);

    always_comb begin
        o_srch = '0;
        // Valid ids are unique, so at most one entry matches and the
        // stored masks can simply be ORed together.
        for (int i = 0; i < ucap_pkg::ENTRIES; i++) begin
            if (i_tbl[i].valid && (i_tbl[i].user_id == i_user_id)) begin
                o_srch.hit  = 1'b1;
                o_srch.caps = o_srch.caps | i_tbl[i].caps;
            end
        end
        // Scan downwards so that the lowest free slot wins.
        for (int i = ucap_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!i_tbl[i].valid) begin
                o_srch.has_free = 1'b1;
                o_srch.free_idx = ucap_pkg::IDX_W'(i);
            end
        end
    end

endmodule

/* test/tb_user_capability_table_unit.sv */
`timescale 1ns / 1ps

module tb_user_capability_table_unit;

    import ucap_pkg::*;

    typedef struct packed {
        logic              success;
        logic [CAPS_W-1:0] caps;
        logic              covers;
    } t_table_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [ID_W-1:0]   i_user_id;
    logic [CAPS_W-1:0] i_grant_mask;
    logic [CAPS_W-1:0] i_required_mask;
    logic              o_done;
    logic              o_success;
    logic [CAPS_W-1:0] o_granted_caps;
    logic              o_covers_required;

    // Shadow copy of the user table, updated as each request is accepted.
    logic              tbl_valid [ENTRIES];
    logic [ID_W-1:0]   tbl_id    [ENTRIES];
    logic [CAPS_W-1:0] tbl_caps  [ENTRIES];

    t_table_reply awaited_replies[$];

    int n_errors;
    int n_requests;
    int n_creates_stored;
    int n_creates_refused;
    int n_query_hits;
    int n_query_misses;
    int n_replies_seen;

    user_capability_table_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_user_id         (i_user_id),
        .i_grant_mask      (i_grant_mask),
        .i_required_mask   (i_required_mask),
        .o_done            (o_done),
        .o_success         (o_success),
        .o_granted_caps    (o_granted_caps),
        .o_covers_required (o_covers_required)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("%0t ns: run did not complete in time", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_table_reply compute_table_reply(input logic kind,
                                                         input logic [ID_W-1:0] id,
                                                         input logic [CAPS_W-1:0] grant,
                                                         input logic [CAPS_W-1:0] req);
        t_table_reply r;
        int hit;
        int slot;
        r = '0;
        hit = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_id[i] == id) hit = i;
        end
        if (kind == KIND_CREATE) begin
            if (hit < 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                end
                if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_id[slot]    = id;
                    tbl_caps[slot]  = grant;
                    r.success       = 1'b1;
                end
            end
        end else begin
            if (hit >= 0) begin
                r.success = 1'b1;
                r.caps    = tbl_caps[hit];
            end
            r.covers = ((r.caps & req) == req);
        end
        return r;
    endfunction

    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [CAPS_W-1:0] grant,
                                input logic [CAPS_W-1:0] req);
        t_table_reply r;
        @(negedge i_clk);
        start           <= 1'b1;
        i_kind          <= kind;
        i_user_id       <= id;
        i_grant_mask    <= grant;
        i_required_mask <= req;
        do @(posedge i_clk); while (busy);
        r = compute_table_reply(kind, id, grant, req);
        awaited_replies.push_back(r);
        n_requests++;
        if (kind == KIND_CREATE) begin
            if (r.success) n_creates_stored++;
            else n_creates_refused++;
        end else begin
            if (r.success) n_query_hits++;
            else n_query_misses++;
        end
    endtask

    // Start is dropped on the first falling edge; the fields carry junk meanwhile.
    task automatic hold_off(input int cycles);
        for (int i = 0; i < cycles; i++) begin
            @(negedge i_clk);
            start           <= 1'b0;
            i_kind          <= 1'($urandom);
            i_user_id       <= ID_W'($urandom);
            i_grant_mask    <= $urandom;
            i_required_mask <= $urandom;
        end
    endtask

    task automatic wait_for_replies();
        int guard;
        guard = 0;
        while (awaited_replies.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && $isunknown(o_done)) begin
            $display("%0t ns: result strobe unknown, expected 0 or 1, actual %b",
                     $time, o_done);
            n_errors++;
        end else if (i_rst_n && o_done) begin
            n_replies_seen++;
            if (awaited_replies.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %b/%h/%b",
                         $time, o_success, o_granted_caps, o_covers_required);
                n_errors++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_success !== want.success) begin
                    $display("%0t ns: success mismatch, expected %b, actual %b",
                             $time, want.success, o_success);
                    n_errors++;
                end
                if (o_granted_caps !== want.caps) begin
                    $display("%0t ns: granted_caps mismatch, expected %h, actual %h",
                             $time, want.caps, o_granted_caps);
                    n_errors++;
                end
                if (o_covers_required !== want.covers) begin
                    $display("%0t ns: covers_required mismatch, expected %b, actual %b",
                             $time, want.covers, o_covers_required);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_root_entry();
        send_request(KIND_QUERY, ROOT_ID, 32'h0, ROOT_CAPS);
        send_request(KIND_QUERY, ROOT_ID, ROOT_CAPS, 32'h0);
        send_request(KIND_QUERY, 16'hFFFF, 32'h0, 32'h0);
        send_request(KIND_QUERY, 16'h8000, ROOT_CAPS, 32'h0000_0001);
        send_request(KIND_QUERY, 16'h0001, 32'h0, ROOT_CAPS);
        // The root id is already present, so this create must be refused.
        send_request(KIND_CREATE, ROOT_ID, 32'h1234_5678, ROOT_CAPS);
    endtask

    task automatic test_create_entries();
        send_request(KIND_CREATE, 16'hFFFF, 32'h0, ROOT_CAPS);
        send_request(KIND_CREATE, 16'h0001, ROOT_CAPS, 32'h0);
        send_request(KIND_CREATE, 16'h5A5A, 32'hA5A5_A5A5, 32'h0);
        send_request(KIND_CREATE, 16'hAAAA, 32'h5555_5555, 32'hFFFF_0000);
        send_request(KIND_CREATE, 16'hFFFF, ROOT_CAPS, 32'h0);
        send_request(KIND_QUERY, 16'hFFFF, 32'h0, 32'h0);
        send_request(KIND_QUERY, 16'hFFFF, 32'h0, 32'h0000_0001);
        send_request(KIND_QUERY, 16'h5A5A, 32'h0, 32'h8000_0001);
        send_request(KIND_QUERY, 16'hAAAA, ROOT_CAPS, 32'hAAAA_AAAA);
        send_request(KIND_QUERY, 16'hAAAA, 32'h0, 32'h5555_5555);
        send_request(KIND_QUERY, 16'h0001, 32'h0, ROOT_CAPS);
    endtask

    task automatic test_drain_pause();
        hold_off(1);
        wait_for_replies();
        send_request(KIND_QUERY, ROOT_ID, 32'h0, 32'h8000_0000);
    endtask

    // Mostly lookups of ids held in the table, so that hits and coverage
    // checks dominate; the rest are misses, fresh creates and duplicates.
    task automatic test_random_traffic(input int count, input bit with_gaps);
        int pick;
        int idx;
        logic [CAPS_W-1:0] caps;
        logic [CAPS_W-1:0] req;
        logic [CAPS_W-1:0] grant;
        for (int n = 0; n < count; n++) begin
            if (with_gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
            pick = $urandom_range(0, 99);
            idx = $urandom_range(0, ENTRIES - 1);
            while (!tbl_valid[idx]) idx = $urandom_range(0, ENTRIES - 1);
            if (pick < 55) begin
                caps = tbl_caps[idx];
                case ($urandom_range(0, 3))
                    0: req = caps & $urandom;
                    1: req = caps;
                    2: req = $urandom;
                    default: req = '0;
                endcase
                send_request(KIND_QUERY, tbl_id[idx], $urandom, req);
            end else if (pick < 75) begin
                req = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
                send_request(KIND_QUERY, ID_W'($urandom), $urandom, req);
            end else if (pick < 90) begin
                case ($urandom_range(0, 3))
                    0: grant = '0;
                    1: grant = '1;
                    default: grant = $urandom;
                endcase
                send_request(KIND_CREATE, ID_W'($urandom), grant, $urandom);
            end else begin
                send_request(KIND_CREATE, tbl_id[idx], $urandom, $urandom);
            end
        end
    endtask

    initial begin
        start           = 1'b0;
        i_kind          = KIND_CREATE;
        i_user_id       = '0;
        i_grant_mask    = '0;
        i_required_mask = '0;
        i_rst_n         = 1'b0;
        n_errors          = 0;
        n_requests        = 0;
        n_creates_stored  = 0;
        n_creates_refused = 0;
        n_query_hits      = 0;
        n_query_misses    = 0;
        n_replies_seen    = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i]    = '0;
            tbl_caps[i]  = '0;
        end
        tbl_valid[0] = 1'b1;
        tbl_id[0]    = ROOT_ID;
        tbl_caps[0]  = ROOT_CAPS;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_root_entry();
        test_create_entries();
        test_random_traffic(500, 1'b1);
        test_drain_pause();
        test_random_traffic(380, 1'b0);

        hold_off(1);
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        if (awaited_replies.size() != 0) begin
            $display("%0t ns: %0d results missing, expected 0 outstanding, actual %0d",
                     $time, awaited_replies.size(), awaited_replies.size());
            n_errors += awaited_replies.size();
        end

        $display("Sent %0d requests and checked %0d results.", n_requests, n_replies_seen);
        $display("Creates stored %0d, refused %0d; lookups hit %0d, missed %0d.",
                 n_creates_stored, n_creates_refused, n_query_hits, n_query_misses);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
